// File: sv/hdq_pkg.sv
// shared types, constants and the register file power-up table for the hdq slave
package hdq_pkg;

    localparam int REG_COUNT  = 128;
    localparam int REG_ADDR_W = $clog2(REG_COUNT);

    typedef enum logic [1:0] {
        OP_PULSE       = 2'd0,
        OP_LOCAL_WRITE = 2'd1,
        OP_LOCAL_READ  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        KIND_BREAK      = 3'd0,
        KIND_HOST_WRITE = 3'd1,
        KIND_TX_SLOT    = 3'd2,
        KIND_LOCAL_READ = 3'd3,
        KIND_CMD_ACK    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CFG_BREAK_MIN     = 3'd0,
        CFG_ONE_BIT_MAX   = 3'd1,
        CFG_TX_ONE_LOW    = 3'd2,
        CFG_TX_ZERO_LOW   = 3'd3,
        CFG_TX_BIT_PERIOD = 3'd4,
        CFG_RESP_DELAY    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] break_min_us;
        logic [15:0] one_bit_max_us;
        logic [9:0]  tx_one_low_us;
        logic [9:0]  tx_zero_low_us;
        logic [9:0]  tx_bit_period_us;
        logic [9:0]  response_delay_us;
    } cfg_t;

    // register file access issued together with an accepted transaction
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic       in_range;
        logic [6:0] addr;
        logic [7:0] wdata;
    } mem_req_t;

    // result run handed from the decoder to the slot sequencer
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [6:0] addr;
        logic [7:0] data;
        logic       from_mem;
    } job_t;

    localparam logic [7:0] INIT_TABLE [128] = '{
        8'h00,8'h00,8'h01,8'h00,8'h01,8'h00,8'h04,8'h9c,
        8'h0f,8'ha0,8'h10,8'h3c,8'h03,8'he8,8'h03,8'he8,
        8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
        8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,
        8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
        8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,
        8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
        8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,
        8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
        8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,
        8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
        8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,
        8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
        8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,
        8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
        8'h08,8'h09,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15
    };

    function automatic logic [7:0] init_byte(input logic [6:0] addr);
        return INIT_TABLE[addr];
    endfunction

endpackage

// File: sv/hdq_ram.sv
// generic single-clock ram, one write port and one registered read port
module hdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/hdq_regfile.sv
// register file: ram plus per-entry written bits, unwritten entries read the power-up table
module hdq_regfile (
    input  logic              aclk,
    input  logic              aresetn,
    input  hdq_pkg::mem_req_t req,
    output logic [7:0]        rd_byte
);
    import hdq_pkg::*;

    logic [REG_COUNT-1:0]  written_reg;
    logic                  vld_q_reg;
    logic                  range_q_reg;
    logic [6:0]            addr_q_reg;
    logic [7:0]            ram_q;
    logic [REG_ADDR_W-1:0] idx;

    assign idx = req.addr[REG_ADDR_W-1:0];

    hdq_ram #(
        .WIDTH(8),
        .DEPTH(REG_COUNT)
    ) u_ram (
        .aclk (aclk),
        .we   (req.wr_en),
        .waddr(idx),
        .wdata(req.wdata),
        .re   (req.rd_en),
        .raddr(idx),
        .rdata(ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (req.wr_en) begin
            written_reg[idx] <= 1'b1;
        end
    end

    // read side info held alongside the ram output until the next read
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            vld_q_reg   <= written_reg[idx];
            range_q_reg <= req.in_range;
            addr_q_reg  <= req.addr;
        end
    end

    assign rd_byte = !range_q_reg ? 8'h00 :
                     vld_q_reg    ? ram_q : init_byte(addr_q_reg);

endmodule

// File: sv/hdq_rx.sv
// frame decoder: break detection, bit assembly, command handling and local access
module hdq_rx (
    input  logic              aclk,
    input  logic              aresetn,
    input  hdq_pkg::cfg_t     cfg,
    input  logic              accept,
    input  logic [1:0]        s_opcode,
    input  logic [15:0]       s_pulse_us,
    input  logic [7:0]        s_local_addr,
    input  logic [7:0]        s_local_value,
    output hdq_pkg::job_t     job,
    output hdq_pkg::mem_req_t req
);
    import hdq_pkg::*;

    logic       receiving_reg, receiving_next;
    logic       past_cmd_reg, past_cmd_next;
    logic [2:0] bit_idx_reg, bit_idx_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] cmd_reg, cmd_next;
    logic       local_in_range;
    logic       cmd_in_range;
    logic       is_break;

    assign local_in_range = 32'(s_local_addr) < REG_COUNT;
    assign cmd_in_range   = 32'(cmd_reg[6:0]) < REG_COUNT;
    assign is_break       = s_pulse_us > cfg.break_min_us;

    always_comb begin
        receiving_next = receiving_reg;
        past_cmd_next  = past_cmd_reg;
        bit_idx_next   = bit_idx_reg;
        shift_next     = shift_reg;
        cmd_next       = cmd_reg;
        job            = '0;
        req            = '0;
        if (accept) begin
            case (op_t'(s_opcode))
                OP_LOCAL_WRITE: begin
                    req.wr_en = local_in_range;
                    req.addr  = s_local_addr[6:0];
                    req.wdata = s_local_value;
                end
                OP_LOCAL_READ: begin
                    req.rd_en     = 1'b1;
                    req.in_range  = local_in_range;
                    req.addr      = s_local_addr[6:0];
                    job.valid     = 1'b1;
                    job.kind      = KIND_LOCAL_READ;
                    job.addr      = s_local_addr[6:0];
                    job.from_mem  = 1'b1;
                end
                OP_PULSE: begin
                    if (!receiving_reg) begin
                        if (is_break) begin
                            receiving_next = 1'b1;
                            past_cmd_next  = 1'b0;
                            bit_idx_next   = '0;
                            shift_next     = '0;
                            job.valid      = 1'b1;
                            job.kind       = KIND_BREAK;
                        end
                    end else if (is_break) begin
                        // overlong data pulse aborts the frame
                        receiving_next = 1'b0;
                        bit_idx_next   = '0;
                    end else begin
                        shift_next   = {s_pulse_us < cfg.one_bit_max_us, shift_reg[7:1]};
                        bit_idx_next = bit_idx_reg + 3'd1;
                        if (bit_idx_reg == 3'd7) begin
                            if (past_cmd_reg) begin
                                req.wr_en = cmd_in_range;
                                req.addr  = cmd_reg[6:0];
                                req.wdata = shift_next;
                                job.valid = 1'b1;
                                job.kind  = KIND_HOST_WRITE;
                                job.addr  = cmd_reg[6:0];
                                job.data  = shift_next;
                            end else begin
                                cmd_next  = shift_next;
                                job.valid = 1'b1;
                                job.addr  = shift_next[6:0];
                                if (shift_next[7]) begin
                                    past_cmd_next = 1'b1;
                                    job.kind      = KIND_CMD_ACK;
                                    job.data      = shift_next;
                                end else begin
                                    // read command: reply then wait for a new break
                                    receiving_next = 1'b0;
                                    past_cmd_next  = 1'b0;
                                    req.rd_en      = 1'b1;
                                    req.in_range   = 32'(shift_next[6:0]) < REG_COUNT;
                                    req.addr       = shift_next[6:0];
                                    job.kind       = KIND_TX_SLOT;
                                    job.from_mem   = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg <= 1'b0;
            past_cmd_reg  <= 1'b0;
            bit_idx_reg   <= '0;
            shift_reg     <= '0;
            cmd_reg       <= '0;
        end else begin
            receiving_reg <= receiving_next;
            past_cmd_reg  <= past_cmd_next;
            bit_idx_reg   <= bit_idx_next;
            shift_reg     <= shift_next;
            cmd_reg       <= cmd_next;
        end
    end

endmodule

// File: sv/hdq_tx.sv
// result sequencer: holds one run, steps transmit slots, drives the output register
module hdq_tx (
    input  logic          aclk,
    input  logic          aresetn,
    input  hdq_pkg::cfg_t cfg,
    input  hdq_pkg::job_t job_in,
    input  logic [7:0]    rd_byte,
    output logic          job_free,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_kind,
    output logic [6:0]    m_reg_addr,
    output logic [7:0]    m_data_byte,
    output logic [9:0]    m_lead_high_us,
    output logic [9:0]    m_low_us,
    output logic [9:0]    m_high_us,
    output logic          m_bit_value,
    output logic          m_last
);
    import hdq_pkg::*;

    job_t       job_reg;
    logic [2:0] slot_reg;
    logic       m_valid_reg;
    logic [2:0] kind_reg;
    logic [6:0] addr_reg;
    logic [7:0] data_reg;
    logic [9:0] lead_reg, low_reg, high_reg;
    logic       bit_reg, last_reg;

    logic       out_free, emit, is_tx, done;
    logic [7:0] byte_val;
    logic       b;
    logic [9:0] low_val, high_val;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = job_reg.valid && out_free;
    assign is_tx    = job_reg.kind == KIND_TX_SLOT;
    assign done     = emit && (!is_tx || slot_reg == 3'd7);
    assign job_free = !job_reg.valid || done;

    assign byte_val = job_reg.from_mem ? rd_byte : job_reg.data;
    assign b        = byte_val[slot_reg];
    assign low_val  = b ? cfg.tx_one_low_us : cfg.tx_zero_low_us;
    assign high_val = (cfg.tx_bit_period_us > low_val) ?
                      cfg.tx_bit_period_us - low_val : 10'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg     <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (job_free) begin
                job_reg  <= job_in;
                slot_reg <= '0;
            end else if (emit) begin
                slot_reg <= slot_reg + 3'd1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg <= job_reg.kind;
            addr_reg <= job_reg.addr;
            data_reg <= byte_val;
            if (is_tx) begin
                lead_reg <= (slot_reg == 3'd0) ? cfg.response_delay_us : 10'd0;
                low_reg  <= low_val;
                high_reg <= high_val;
                bit_reg  <= b;
                last_reg <= slot_reg == 3'd7;
            end else begin
                lead_reg <= '0;
                low_reg  <= '0;
                high_reg <= '0;
                bit_reg  <= 1'b0;
                last_reg <= 1'b1;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_reg_addr     = addr_reg;
    assign m_data_byte    = data_reg;
    assign m_lead_high_us = lead_reg;
    assign m_low_us       = low_reg;
    assign m_high_us      = high_reg;
    assign m_bit_value    = bit_reg;
    assign m_last         = last_reg;

endmodule

// File: sv/hdq_slave_register_file.sv
// top level of the single-wire hdq slave with its byte register file
//
// s_ channel: one transaction per measured line low pulse (opcode 0) or per
// local register write (1) or read (2). m_ channel: result transactions, one
// per break, command ack, host write or local read, eight per read command
// (one transmit slot per bit, lsb first); m_last marks the end of each run.
// cfg_ channel: always ready, writes timing register cfg_index with cfg_data;
// indexes past the last register are dropped. write it only while idle.
// flow: an accepted transaction's run waits in the sequencer's run register
// and moves on into the output register. a run of n results leaves the slot
// sequencer one per cycle while m_ready is high, so a read command holds
// s_ready low until its last slot is emitted and other transactions can be
// accepted every cycle; the output register sets this rate, it accepts the
// next transaction when the current run's last result moves into it. the
// register file does one ram read at acceptance, data ready the cycle after.
// reset: frame state returns to awaiting break, timing registers go to
// their defaults and the written bits clear, so every entry reads its
// power-up value at once; no clearing pass.
// stall: with m_ready low the output register holds, the sequencer keeps
// one run waiting and s_ready drops until that run can drain.
module hdq_slave_register_file (
    input  logic        aclk,
    input  logic        aresetn,
    // input transactions
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [15:0] s_pulse_us,
    input  logic [7:0]  s_local_addr,
    input  logic [7:0]  s_local_value,
    // result transactions
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [6:0]  m_reg_addr,
    output logic [7:0]  m_data_byte,
    output logic [9:0]  m_lead_high_us,
    output logic [9:0]  m_low_us,
    output logic [9:0]  m_high_us,
    output logic        m_bit_value,
    output logic        m_last,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import hdq_pkg::*;

    cfg_t     cfg_reg;
    job_t     job;
    mem_req_t req;
    logic     accept;
    logic [7:0] rd_byte;

    // config port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.break_min_us      <= 16'd190;
            cfg_reg.one_bit_max_us    <= 16'd50;
            cfg_reg.tx_one_low_us     <= 10'd20;
            cfg_reg.tx_zero_low_us    <= 10'd120;
            cfg_reg.tx_bit_period_us  <= 10'd200;
            cfg_reg.response_delay_us <= 10'd100;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_BREAK_MIN:     cfg_reg.break_min_us      <= cfg_data;
                CFG_ONE_BIT_MAX:   cfg_reg.one_bit_max_us    <= cfg_data;
                CFG_TX_ONE_LOW:    cfg_reg.tx_one_low_us     <= cfg_data[9:0];
                CFG_TX_ZERO_LOW:   cfg_reg.tx_zero_low_us    <= cfg_data[9:0];
                CFG_TX_BIT_PERIOD: cfg_reg.tx_bit_period_us  <= cfg_data[9:0];
                CFG_RESP_DELAY:    cfg_reg.response_delay_us <= cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // input transaction taken whenever the sequencer can load a new run
    assign accept = s_valid && s_ready;

    hdq_rx u_rx (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .accept       (accept),
        .s_opcode     (s_opcode),
        .s_pulse_us   (s_pulse_us),
        .s_local_addr (s_local_addr),
        .s_local_value(s_local_value),
        .job          (job),
        .req          (req)
    );

    // register file, written and read at the acceptance edge
    hdq_regfile u_regfile (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (req),
        .rd_byte(rd_byte)
    );

    hdq_tx u_tx (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .job_in        (job),
        .rd_byte       (rd_byte),
        .job_free      (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_reg_addr    (m_reg_addr),
        .m_data_byte   (m_data_byte),
        .m_lead_high_us(m_lead_high_us),
        .m_low_us      (m_low_us),
        .m_high_us     (m_high_us),
        .m_bit_value   (m_bit_value),
        .m_last        (m_last)
    );

    // single-result runs always carry last and no slot timing
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_TX_SLOT |-> m_last && m_low_us == 10'd0 &&
        m_high_us == 10'd0 && m_lead_high_us == 10'd0)
        else $error("non-slot result with slot fields or without last");

    // a taken slot that is not the last is followed by the next slot
    a_slot_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_kind == KIND_TX_SLOT && !m_last |=>
        m_valid && m_kind == KIND_TX_SLOT)
        else $error("transmit run broken up");

    // no new input while a stalled reply still has slots to send
    a_no_accept_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && m_kind == KIND_TX_SLOT && !m_last |-> !s_ready)
        else $error("input accepted during a pending transmit run");

    // only the first slot of a reply carries the response delay
    a_lead_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_kind == KIND_TX_SLOT && !m_last |=>
        m_lead_high_us == 10'd0)
        else $error("lead high time on a later slot");

endmodule
